// File: hw/rtl/ggvg_pkg.sv
package ggvg_pkg;

  localparam int VERTICES   = 32;
  localparam int MAX_EDGES  = 1024;
  localparam int VERT_W     = 5;
  localparam int GAIN_W     = 16;
  localparam int TOTAL_W    = 32;
  localparam int ADDR_W     = $clog2(MAX_EDGES);
  localparam int CNT_W      = ADDR_W + 1;
  // |sum| <= MAX_EDGES * 32767 fits in ADDR_W + GAIN_W signed bits
  localparam int SCORE_W    = ADDR_W + GAIN_W;
  localparam int EDGE_W     = 2 * VERT_W + GAIN_W + 1;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = -32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_RUN   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_PAIR  = 2'd0,
    KIND_ADDED = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SCAN_START = 2'd0,
    SCAN_ACC   = 2'd1,
    SCAN_SEL   = 2'd2,
    SCAN_MAX   = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ACC,
    ST_SEL,
    ST_MAX
  } state_e;

  typedef struct packed {
    logic       load_edge;
    logic       clear_list;
    logic       init_run;
    logic       scan_go;
    scan_mode_e scan_mode;
    logic       commit_pair;
    logic       commit_add;
    logic       emit_done;
    logic       emit_none;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
  } status_t;

endpackage

// File: hw/rtl/ggvg_ctrl.sv
module ggvg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        func_i,
  input  ggvg_pkg::status_t status_i,
  output ggvg_pkg::cmd_t    cmd_o,
  output logic              busy
);

  ggvg_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = start && (state_q == ggvg_pkg::ST_IDLE);
  assign busy   = (state_q != ggvg_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ggvg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ggvg_pkg::ST_IDLE: begin
        if (accept && func_i == ggvg_pkg::FUNC_RUN) state_d = ggvg_pkg::ST_START;
      end
      ggvg_pkg::ST_START: begin
        if (status_i.scan_done) begin
          state_d = status_i.found ? ggvg_pkg::ST_ACC : ggvg_pkg::ST_IDLE;
        end
      end
      ggvg_pkg::ST_ACC: begin
        if (status_i.scan_done) state_d = ggvg_pkg::ST_SEL;
      end
      ggvg_pkg::ST_SEL: begin
        if (status_i.scan_done) begin
          state_d = status_i.found ? ggvg_pkg::ST_MAX : ggvg_pkg::ST_IDLE;
        end
      end
      ggvg_pkg::ST_MAX: begin
        if (status_i.scan_done) state_d = ggvg_pkg::ST_ACC;
      end
      default: state_d = ggvg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.scan_mode = ggvg_pkg::SCAN_START;
    case (state_q)
      ggvg_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.load_edge  = (func_i == ggvg_pkg::FUNC_LOAD);
          cmd_o.clear_list = (func_i == ggvg_pkg::FUNC_CLEAR);
          if (func_i == ggvg_pkg::FUNC_RUN) begin
            cmd_o.init_run  = 1'b1;
            cmd_o.scan_go   = 1'b1;
            cmd_o.scan_mode = ggvg_pkg::SCAN_START;
          end
        end
      end
      ggvg_pkg::ST_START: begin
        if (status_i.scan_done) begin
          if (status_i.found) begin
            cmd_o.commit_pair = 1'b1;
            cmd_o.scan_go     = 1'b1;
            cmd_o.scan_mode   = ggvg_pkg::SCAN_ACC;
          end else begin
            cmd_o.emit_none = 1'b1;
          end
        end
      end
      ggvg_pkg::ST_ACC: begin
        if (status_i.scan_done) begin
          cmd_o.scan_go   = 1'b1;
          cmd_o.scan_mode = ggvg_pkg::SCAN_SEL;
        end
      end
      ggvg_pkg::ST_SEL: begin
        if (status_i.scan_done) begin
          if (status_i.found) begin
            cmd_o.scan_go   = 1'b1;
            cmd_o.scan_mode = ggvg_pkg::SCAN_MAX;
          end else begin
            cmd_o.emit_done = 1'b1;
          end
        end
      end
      ggvg_pkg::ST_MAX: begin
        if (status_i.scan_done) begin
          cmd_o.commit_add = 1'b1;
          cmd_o.scan_go    = 1'b1;
          cmd_o.scan_mode  = ggvg_pkg::SCAN_ACC;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/ggvg_datapath.sv
module ggvg_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ggvg_pkg::cmd_t                        cmd_i,
  input  logic [ggvg_pkg::VERT_W-1:0]           src_vertex_i,
  input  logic [ggvg_pkg::VERT_W-1:0]           dst_vertex_i,
  input  logic signed [ggvg_pkg::GAIN_W-1:0]    edge_gain_i,
  input  logic                                  forbidden_i,
  output ggvg_pkg::status_t                     status_o,
  output logic                                  strobe_o,
  output logic [1:0]                            kind_o,
  output logic [ggvg_pkg::VERT_W-1:0]           vertex_a_o,
  output logic [ggvg_pkg::VERT_W-1:0]           vertex_b_o,
  output logic signed [ggvg_pkg::GAIN_W-1:0]    step_gain_o,
  output logic                                  gain_counted_o,
  output logic signed [ggvg_pkg::TOTAL_W-1:0]   total_gain_o,
  output logic                                  last_o
);

  localparam int AW = ggvg_pkg::ADDR_W;
  localparam int CW = ggvg_pkg::CNT_W;
  localparam int VW = ggvg_pkg::VERT_W;
  localparam int GW = ggvg_pkg::GAIN_W;
  localparam int SW = ggvg_pkg::SCORE_W;
  localparam int TW = ggvg_pkg::TOTAL_W;
  localparam int NV = ggvg_pkg::VERTICES;

  // edge memory, packed {forbidden, gain, dst, src}
  logic [ggvg_pkg::EDGE_W-1:0] mem [ggvg_pkg::MAX_EDGES];
  logic [ggvg_pkg::EDGE_W-1:0] rd_q;

  logic [CW-1:0]   cnt_q;
  logic [AW-1:0]   addr_q;
  logic            issue_q, rd_valid_q, active_q;
  ggvg_pkg::scan_mode_e mode_q;
  logic [NV-1:0]   group_q, barred_q, sc_valid_q;
  logic            found_q;
  logic signed [TW-1:0] total_q;

  logic signed [SW-1:0] score_q [NV];
  logic signed [SW-1:0] top_q;
  logic signed [GW-1:0] best_q;
  logic [VW-1:0]        s_q, d_q;

  logic [VW-1:0]        e_src, e_dst;
  logic signed [GW-1:0] e_gain;
  logic                 e_forb, e_src_in, e_dst_in;
  logic signed [SW-1:0] sc_cur;
  logic                 scan_done, we;
  logic                 upd_start, upd_sel, upd_max, acc_hit;
  logic signed [TW:0]   sum_w;
  logic signed [TW-1:0] total_sat;
  logic signed [GW-1:0] addend;

  assign e_src    = rd_q[VW-1:0];
  assign e_dst    = rd_q[2*VW-1:VW];
  assign e_gain   = rd_q[2*VW+GW-1:2*VW];
  assign e_forb   = rd_q[ggvg_pkg::EDGE_W-1];
  assign e_src_in = group_q[e_src];
  assign e_dst_in = group_q[e_dst];
  assign sc_cur   = sc_valid_q[e_src] ? score_q[e_src] : '0;

  assign scan_done = active_q && !issue_q && !rd_valid_q;
  assign status_o.scan_done = scan_done;
  assign status_o.found     = found_q;

  assign we = cmd_i.load_edge && (cnt_q < CW'(ggvg_pkg::MAX_EDGES));

  assign upd_start = rd_valid_q && (mode_q == ggvg_pkg::SCAN_START) && !e_forb &&
                     (!found_q || e_gain > best_q);
  assign acc_hit   = rd_valid_q && (mode_q == ggvg_pkg::SCAN_ACC) && !e_src_in && e_dst_in;
  assign upd_sel   = rd_valid_q && (mode_q == ggvg_pkg::SCAN_SEL) && !e_src_in &&
                     !barred_q[e_src] && (!found_q || sc_cur > top_q);
  assign upd_max   = rd_valid_q && (mode_q == ggvg_pkg::SCAN_MAX) && (e_src == s_q) &&
                     e_dst_in && !e_forb && (!found_q || e_gain > best_q);

  // saturating total update
  assign addend = (cmd_i.commit_add && !found_q) ? '0 : best_q;
  assign sum_w  = {total_q[TW-1], total_q} + (TW+1)'(addend);
  always_comb begin
    if (sum_w > (TW+1)'(ggvg_pkg::TOTAL_MAX)) total_sat = ggvg_pkg::TOTAL_MAX;
    else if (sum_w < (TW+1)'(ggvg_pkg::TOTAL_MIN))
      total_sat = ggvg_pkg::TOTAL_MIN;
    else total_sat = sum_w[TW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[cnt_q[AW-1:0]] <= {forbidden_i, edge_gain_i, dst_vertex_i, src_vertex_i};
    if (issue_q) rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      addr_q     <= '0;
      issue_q    <= 1'b0;
      rd_valid_q <= 1'b0;
      active_q   <= 1'b0;
      mode_q     <= ggvg_pkg::SCAN_START;
      group_q    <= '0;
      barred_q   <= '0;
      sc_valid_q <= '0;
      found_q    <= 1'b0;
      total_q    <= '0;
      strobe_o   <= 1'b0;
    end else begin
      rd_valid_q <= issue_q;
      if (we) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.clear_list) cnt_q <= '0;
      if (issue_q) begin
        addr_q <= addr_q + 1'b1;
        if (({1'b0, addr_q} + 1'b1) == cnt_q) issue_q <= 1'b0;
      end
      if (scan_done && !cmd_i.scan_go) active_q <= 1'b0;

      if (upd_start || upd_sel || upd_max) found_q <= 1'b1;
      if (acc_hit) begin
        if (e_forb) barred_q[e_src] <= 1'b1;
        else sc_valid_q[e_src] <= 1'b1;
      end

      if (cmd_i.init_run) begin
        group_q <= '0;
        total_q <= '0;
      end
      if (cmd_i.commit_pair) begin
        group_q[s_q] <= 1'b1;
        group_q[d_q] <= 1'b1;
        total_q      <= total_sat;
      end
      if (cmd_i.commit_add) begin
        group_q[s_q] <= 1'b1;
        total_q      <= total_sat;
      end
      strobe_o <= cmd_i.commit_pair || cmd_i.commit_add || cmd_i.emit_done ||
                  cmd_i.emit_none;

      if (cmd_i.scan_go) begin
        active_q <= 1'b1;
        mode_q   <= cmd_i.scan_mode;
        addr_q   <= '0;
        issue_q  <= (cnt_q != '0);
        if (cmd_i.scan_mode != ggvg_pkg::SCAN_ACC) found_q <= 1'b0;
        if (cmd_i.scan_mode == ggvg_pkg::SCAN_ACC) begin
          barred_q   <= '0;
          sc_valid_q <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_hit && !e_forb) score_q[e_src] <= sc_cur + SW'(e_gain);
    if (upd_start) begin
      best_q <= e_gain;
      s_q    <= e_src;
      d_q    <= e_dst;
    end
    if (upd_sel) begin
      top_q <= sc_cur;
      s_q   <= e_src;
    end
    if (upd_max) best_q <= e_gain;

    if (cmd_i.commit_pair) begin
      kind_o         <= ggvg_pkg::KIND_PAIR;
      vertex_a_o     <= s_q;
      vertex_b_o     <= d_q;
      step_gain_o    <= best_q;
      gain_counted_o <= 1'b1;
      total_gain_o   <= total_sat;
      last_o         <= 1'b0;
    end
    if (cmd_i.commit_add) begin
      kind_o         <= ggvg_pkg::KIND_ADDED;
      vertex_a_o     <= s_q;
      vertex_b_o     <= '0;
      step_gain_o    <= found_q ? best_q : '0;
      gain_counted_o <= found_q;
      total_gain_o   <= total_sat;
      last_o         <= 1'b0;
    end
    if (cmd_i.emit_done || cmd_i.emit_none) begin
      kind_o         <= cmd_i.emit_done ? ggvg_pkg::KIND_DONE : ggvg_pkg::KIND_NONE;
      vertex_a_o     <= '0;
      vertex_b_o     <= '0;
      step_gain_o    <= '0;
      gain_counted_o <= 1'b0;
      total_gain_o   <= total_q;
      last_o         <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/greedy_gain_vertex_grouping_unit.sv
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+-------------------------
// command  | func_i src_vertex_i dst_vertex_i edge_gain_i   | taken when start & !busy
//          | forbidden_i                                    |
// result   | kind_o vertex_a_o vertex_b_o step_gain_o       | strobe_o, one cycle,
//          | gain_counted_o total_gain_o last_o             | no backpressure
//
// Load and clear do not raise busy; loads may be issued back to back.
// A run walks the edge memory (one read port) once per scan: one scan picks the
// start pair, then three scans per added vertex (score, select, best edge).
// Reset clears the edge count, group and totals; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the final result's cycle.
module greedy_gain_vertex_grouping_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           func_i,
  input  logic [ggvg_pkg::VERT_W-1:0]          src_vertex_i,
  input  logic [ggvg_pkg::VERT_W-1:0]          dst_vertex_i,
  input  logic signed [ggvg_pkg::GAIN_W-1:0]   edge_gain_i,
  input  logic                                 forbidden_i,
  output logic                                 strobe_o,
  output logic [1:0]                           kind_o,
  output logic [ggvg_pkg::VERT_W-1:0]          vertex_a_o,
  output logic [ggvg_pkg::VERT_W-1:0]          vertex_b_o,
  output logic signed [ggvg_pkg::GAIN_W-1:0]   step_gain_o,
  output logic                                 gain_counted_o,
  output logic signed [ggvg_pkg::TOTAL_W-1:0]  total_gain_o,
  output logic                                 last_o
);

  ggvg_pkg::cmd_t    cmd;
  ggvg_pkg::status_t status;

  // controller: decodes commands, sequences the scans of a run
  ggvg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // datapath: edge memory, scan engine, scores, group mask, result register
  ggvg_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .src_vertex_i   (src_vertex_i),
    .dst_vertex_i   (dst_vertex_i),
    .edge_gain_i    (edge_gain_i),
    .forbidden_i    (forbidden_i),
    .status_o       (status),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .vertex_a_o     (vertex_a_o),
    .vertex_b_o     (vertex_b_o),
    .step_gain_o    (step_gain_o),
    .gain_counted_o (gain_counted_o),
    .total_gain_o   (total_gain_o),
    .last_o         (last_o)
  );

  // final result leaves the unit idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy) else $error("busy on final result");

  // a non-final result only shows up mid-run
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy) else $error("intermediate result while idle");

  // results come only from a run
  a_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy)) else $error("result without a run");

  // an empty run reports zero total
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o == ggvg_pkg::KIND_NONE |-> total_gain_o == '0)
    else $error("no-edge result with nonzero total");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // one command transaction as queued for the driver
  typedef struct {
    ggvg_pkg::func_e                    func;
    logic [ggvg_pkg::VERT_W-1:0]        src;
    logic [ggvg_pkg::VERT_W-1:0]        dst;
    logic signed [ggvg_pkg::GAIN_W-1:0] gain;
    logic                               forb;
    int                                 idle_pct;  // chance of an idle cycle before it
    bit                                 drain;     // hold off until all results are out
  } cmd_item_t;

  // one result transaction as predicted
  typedef struct {
    ggvg_pkg::kind_e                     kind;
    logic [ggvg_pkg::VERT_W-1:0]         va;
    logic [ggvg_pkg::VERT_W-1:0]         vb;
    logic signed [ggvg_pkg::GAIN_W-1:0]  sg;
    logic                                counted;
    logic signed [ggvg_pkg::TOTAL_W-1:0] total;
    logic                                last;
  } step_res_t;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func_i = '0;
  logic [ggvg_pkg::VERT_W-1:0] src_vertex_i = '0;
  logic [ggvg_pkg::VERT_W-1:0] dst_vertex_i = '0;
  logic signed [ggvg_pkg::GAIN_W-1:0] edge_gain_i = '0;
  logic forbidden_i = 1'b0;
  logic strobe_o;
  logic [1:0] kind_o;
  logic [ggvg_pkg::VERT_W-1:0] vertex_a_o;
  logic [ggvg_pkg::VERT_W-1:0] vertex_b_o;
  logic signed [ggvg_pkg::GAIN_W-1:0] step_gain_o;
  logic gain_counted_o;
  logic signed [ggvg_pkg::TOTAL_W-1:0] total_gain_o;
  logic last_o;

  greedy_gain_vertex_grouping_unit uut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .src_vertex_i, .dst_vertex_i,
    .edge_gain_i, .forbidden_i, .strobe_o, .kind_o, .vertex_a_o, .vertex_b_o,
    .step_gain_o, .gain_counted_o, .total_gain_o, .last_o
  );

  always #4 clk_i = ~clk_i;

  cmd_item_t cmd_q[$];
  step_res_t step_q[$];
  cmd_item_t cur;
  bit        took = 0;
  int        errors = 0;
  int        cycles = 0;
  int        phase_idle = 0;

  // predictor copy of the edge list
  logic [ggvg_pkg::VERT_W-1:0]        lst_src [ggvg_pkg::MAX_EDGES];
  logic [ggvg_pkg::VERT_W-1:0]        lst_dst [ggvg_pkg::MAX_EDGES];
  logic signed [ggvg_pkg::GAIN_W-1:0] lst_gain[ggvg_pkg::MAX_EDGES];
  logic                               lst_forb[ggvg_pkg::MAX_EDGES];
  int                                 lst_cnt = 0;
  logic signed [ggvg_pkg::TOTAL_W-1:0] run_total;

  function automatic logic signed [ggvg_pkg::TOTAL_W-1:0] sat_add(
      logic signed [ggvg_pkg::TOTAL_W-1:0] t, int g);
    longint s;
    s = longint'(t) + longint'(g);
    if (s > longint'(ggvg_pkg::TOTAL_MAX)) s = longint'(ggvg_pkg::TOTAL_MAX);
    if (s < longint'(ggvg_pkg::TOTAL_MIN)) s = longint'(ggvg_pkg::TOTAL_MIN);
    return s[ggvg_pkg::TOTAL_W-1:0];
  endfunction

  task automatic push_step(ggvg_pkg::kind_e k, int a, int b, int g, bit c, bit l);
    step_res_t r;
    r.kind = k; r.va = ggvg_pkg::VERT_W'(a); r.vb = ggvg_pkg::VERT_W'(b);
    r.sg = ggvg_pkg::GAIN_W'(g); r.counted = c;
    r.total = run_total; r.last = l;
    step_q = {step_q, r};
  endtask

  // greedy grouping over the current list, queues every step result
  task automatic predict_grouping();
    logic [ggvg_pkg::VERTICES-1:0] grp, barred;
    int  sums[ggvg_pkg::VERTICES];
    bit  found, pick, has;
    int  best, top, mx, s, d, nv, a;
    grp = '0; run_total = '0; found = 0; best = 0; s = 0; d = 0;
    for (int i = 0; i < lst_cnt; i++)
      if (!lst_forb[i] && (!found || lst_gain[i] > best)) begin
        found = 1; best = lst_gain[i]; s = lst_src[i]; d = lst_dst[i];
      end
    if (!found) begin
      push_step(ggvg_pkg::KIND_NONE, 0, 0, 0, 0, 1);
      return;
    end
    run_total = sat_add(run_total, best);
    grp[s] = 1'b1; grp[d] = 1'b1;
    push_step(ggvg_pkg::KIND_PAIR, s, d, best, 1, 0);
    forever begin
      pick = 0; has = 0; top = 0; mx = 0; nv = 0; barred = '0;
      for (int v = 0; v < ggvg_pkg::VERTICES; v++) sums[v] = 0;
      for (int i = 0; i < lst_cnt; i++) begin
        a = lst_src[i];
        if (grp[a] || !grp[lst_dst[i]]) continue;
        if (lst_forb[i]) barred[a] = 1'b1;
        else sums[a] += lst_gain[i];
      end
      for (int i = 0; i < lst_cnt; i++) begin
        a = lst_src[i];
        if (grp[a] || barred[a]) continue;
        if (!pick || sums[a] > top) begin
          pick = 1; top = sums[a]; nv = a;
        end
      end
      if (!pick) begin
        push_step(ggvg_pkg::KIND_DONE, 0, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < lst_cnt; i++)
        if (lst_src[i] == nv && grp[lst_dst[i]] && !lst_forb[i] &&
            (!has || lst_gain[i] > mx)) begin
          has = 1; mx = lst_gain[i];
        end
      grp[nv] = 1'b1;
      if (has) begin
        run_total = sat_add(run_total, mx);
        push_step(ggvg_pkg::KIND_ADDED, nv, 0, mx, 1, 0);
      end else begin
        push_step(ggvg_pkg::KIND_ADDED, nv, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic apply_cmd(cmd_item_t c);
    case (c.func)
      ggvg_pkg::FUNC_LOAD: begin
        // both ends always below VERTICES at 5 bits; only the full list drops
        if (lst_cnt < ggvg_pkg::MAX_EDGES) begin
          lst_src[lst_cnt] = c.src; lst_dst[lst_cnt] = c.dst;
          lst_gain[lst_cnt] = c.gain; lst_forb[lst_cnt] = c.forb;
          lst_cnt++;
        end
      end
      ggvg_pkg::FUNC_CLEAR: lst_cnt = 0;
      ggvg_pkg::FUNC_RUN:   predict_grouping();
      default: ;  // unused code is ignored
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic add_cmd(logic [1:0] f, int s, int d, int g, bit fb, bit dr = 0);
    cmd_item_t c;
    c.func = ggvg_pkg::func_e'(f);
    c.src = ggvg_pkg::VERT_W'(s); c.dst = ggvg_pkg::VERT_W'(d);
    c.gain = ggvg_pkg::GAIN_W'(g); c.forb = fb;
    c.idle_pct = phase_idle; c.drain = dr;
    cmd_q = {cmd_q, c};
  endtask

  task automatic add_rand_edge(int span);
    int g;
    if ($urandom_range(3) == 0) g = int'($signed(16'($urandom)));
    else g = int'($urandom_range(40)) - 20;
    if (g == -32768) g = -32767;
    add_cmd(ggvg_pkg::FUNC_LOAD, $urandom_range(span), $urandom_range(span), g,
            $urandom_range(9) == 0);
  endtask

  // monitor: command acceptance feeds the predictor, strobes are checked
  always @(posedge clk_i) begin
    step_res_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && start && !busy) begin
      took = 1;
      apply_cmd(cur);
    end
    if (rst_ni && strobe_o) begin
      if (step_q.size() == 0) begin
        report("unexpected result, kind", kind_o, -1);
      end else begin
        w = step_q.pop_front();
        if (kind_o !== w.kind) report("kind", kind_o, w.kind);
        if (vertex_a_o !== w.va) report("vertex_a", vertex_a_o, w.va);
        if (vertex_b_o !== w.vb) report("vertex_b", vertex_b_o, w.vb);
        if (step_gain_o !== w.sg) report("step_gain", step_gain_o, w.sg);
        if (gain_counted_o !== w.counted) report("gain_counted", gain_counted_o, w.counted);
        if (total_gain_o !== w.total) report("total_gain", total_gain_o, w.total);
        if (last_o !== w.last) report("last", last_o, w.last);
      end
    end
  end

  // driver: holds start until the transaction is taken, then maybe idles
  always @(negedge clk_i) begin
    bit go;
    if (rst_ni && (!start || took)) begin
      took = 0;
      go = cmd_q.size() > 0;
      if (go && cmd_q[0].drain && (step_q.size() > 0 || busy)) go = 0;
      if (go && $urandom_range(99) < cmd_q[0].idle_pct) go = 0;
      if (go) begin
        cur = cmd_q.pop_front();
        func_i <= cur.func;
        src_vertex_i <= cur.src;
        dst_vertex_i <= cur.dst;
        edge_gain_i <= cur.gain;
        forbidden_i <= cur.forb;
      end
      start <= go;
    end
  end

  initial begin
    int k;
    // directed: empty list, forbidden-only list, extremes, self loop,
    // zero-score join, barred vertex, unused code
    add_cmd(ggvg_pkg::FUNC_RUN, 0, 0, 0, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 3, 4, 100, 1);
    add_cmd(ggvg_pkg::FUNC_LOAD, 31, 0, -32767, 1);
    add_cmd(ggvg_pkg::FUNC_RUN, 0, 0, 0, 0);
    add_cmd(ggvg_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 31, 31, 32767, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 0, 31, -32767, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 5, 31, 7, 1);        // bars vertex 5
    add_cmd(ggvg_pkg::FUNC_LOAD, 5, 0, 9, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 9, 12, 3, 0);        // 9 joins with score 0
    add_cmd(2'd3, 31, 31, -1, 1);
    add_cmd(ggvg_pkg::FUNC_RUN, 0, 0, 0, 0);
    add_cmd(ggvg_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 1, 2, -5, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 2, 1, -5, 0);        // tie: first one starts
    add_cmd(ggvg_pkg::FUNC_LOAD, 6, 1, 0, 0);
    add_cmd(ggvg_pkg::FUNC_LOAD, 6, 2, 4, 0);
    add_cmd(ggvg_pkg::FUNC_RUN, 0, 0, 0, 0, 1);
    // random phases of sender idling
    for (int ph = 0; ph < 4; ph++) begin
      phase_idle = (ph == 1) ? 80 : (ph == 3) ? 11 : 0;
      k = 0;
      while (k < 64) begin
        if ($urandom_range(9) != 0) begin
          add_cmd(ggvg_pkg::FUNC_CLEAR, 0, 0, 0, 0); k++;
        end
        for (int j = $urandom_range(12, 1); j > 0; j--) begin
          add_rand_edge($urandom_range(1) ? 31 : 7); k++;
        end
        if ($urandom_range(7) == 0) begin
          add_cmd(2'd3, $urandom, $urandom, $urandom, $urandom_range(1)); k++;
        end
        add_cmd(ggvg_pkg::FUNC_RUN, $urandom, $urandom, $urandom, $urandom_range(1),
                ph == 2 && k < 20);
        k++;
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (cmd_q.size() == 0 && !start && step_q.size() == 0 && !busy);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && step_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: greedy_gain_vertex_grouping_unit.f
hw/rtl/ggvg_pkg.sv
hw/rtl/ggvg_ctrl.sv
hw/rtl/ggvg_datapath.sv
hw/rtl/greedy_gain_vertex_grouping_unit.sv
tb/tb.sv
